FILE: rtl/msl_pkg.sv
// shared constants, types and saturation helper for the muscl slope limiter
// no dependencies; imported by msl_slope_div, msl_vl_div, muscl_slope_limiter and tb_top
package msl_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int DX_W      = 31;
   localparam int MODE_W    = 3;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int SNUM_W    = DIFF_W + FRAC_BITS;
   localparam int VL_N_W    = 2 * DATA_W;
   localparam int VL_D_W    = DATA_W + 1;
   localparam int VL_Q_W    = DATA_W + 1;

   localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VAN_LEER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MINMOD   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              clip;
   } sat_type;

   // signed value from sign and magnitude, clipped to the data range
   function automatic sat_type sat_mag(input logic neg, input logic [SNUM_W-1:0] mag);
      sat_type           r;
      logic [SNUM_W-1:0] lim;
      logic [DATA_W-1:0] m;
      lim = neg ? (SNUM_W'(1) << (DATA_W - 1)) : ((SNUM_W'(1) << (DATA_W - 1)) - SNUM_W'(1));
      r.clip = (mag > lim);
      m = r.clip ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
      r.val = neg ? (~m + DATA_W'(1)) : m;
      return r;
   endfunction

endpackage

FILE: rtl/msl_slope_div.sv
// pipelined restoring divider for one slope, one quotient bit per stage
// depends on msl_pkg
module msl_slope_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [msl_pkg::DIFF_W-1:0]    mag_in,
   input  logic [msl_pkg::DX_W-1:0]      dx_in,
   output logic [msl_pkg::SNUM_W-1:0]    quo_out
);
   import msl_pkg::*;

   logic [DX_W-1:0]   rem_ff [0:SNUM_W];
   logic [SNUM_W-1:0] num_ff [0:SNUM_W];
   logic [SNUM_W-1:0] quo_ff [0:SNUM_W];
   logic [DX_W-1:0]   den_ff [0:SNUM_W];

   logic [DX_W-1:0]   rem_in [0:SNUM_W-1];
   logic              bit_in [0:SNUM_W-1];
   logic [DX_W:0]     shift_w [0:SNUM_W-1];
   logic [DX_W:0]     sub_w   [0:SNUM_W-1];

   always_comb begin
      for (int i = 0; i < SNUM_W; i++) begin
         shift_w[i] = {rem_ff[i], num_ff[i][SNUM_W-1]};
         sub_w[i]   = shift_w[i] - {1'b0, den_ff[i]};
         bit_in[i]  = (shift_w[i] >= {1'b0, den_ff[i]});
         rem_in[i]  = bit_in[i] ? sub_w[i][DX_W-1:0] : shift_w[i][DX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         num_ff[0] <= {mag_in, {FRAC_BITS{1'b0}}};
         quo_ff[0] <= '0;
         den_ff[0] <= dx_in;
         for (int i = 0; i < SNUM_W; i++) begin
            rem_ff[i+1] <= rem_in[i];
            num_ff[i+1] <= {num_ff[i][SNUM_W-2:0], 1'b0};
            quo_ff[i+1] <= {quo_ff[i][SNUM_W-2:0], bit_in[i]};
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   assign quo_out = quo_ff[SNUM_W];

endmodule

FILE: rtl/msl_vl_div.sv
// pipelined restoring divider for the van leer quotient 2ab/(a+b)
// depends on msl_pkg; quotient is known to fit VL_Q_W bits
module msl_vl_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [msl_pkg::VL_N_W-1:0]    num_in,
   input  logic [msl_pkg::VL_D_W-1:0]    den_in,
   output logic [msl_pkg::VL_Q_W-1:0]    quo_out
);
   import msl_pkg::*;

   logic [VL_D_W-1:0] rem_ff [0:VL_Q_W];
   logic [VL_Q_W-1:0] low_ff [0:VL_Q_W];
   logic [VL_Q_W-1:0] quo_ff [0:VL_Q_W];
   logic [VL_D_W-1:0] den_ff [0:VL_Q_W];

   logic [VL_D_W-1:0] rem_in [0:VL_Q_W-1];
   logic              bit_in [0:VL_Q_W-1];
   logic [VL_D_W:0]   shift_w [0:VL_Q_W-1];
   logic [VL_D_W:0]   sub_w   [0:VL_Q_W-1];

   always_comb begin
      for (int i = 0; i < VL_Q_W; i++) begin
         shift_w[i] = {rem_ff[i], low_ff[i][VL_Q_W-1]};
         sub_w[i]   = shift_w[i] - {1'b0, den_ff[i]};
         bit_in[i]  = (shift_w[i] >= {1'b0, den_ff[i]});
         rem_in[i]  = bit_in[i] ? sub_w[i][VL_D_W-1:0] : shift_w[i][VL_D_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= VL_D_W'(num_in[VL_N_W-1:VL_Q_W]);
         low_ff[0] <= num_in[VL_Q_W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         for (int i = 0; i < VL_Q_W; i++) begin
            rem_ff[i+1] <= rem_in[i];
            low_ff[i+1] <= {low_ff[i][VL_Q_W-2:0], 1'b0};
            quo_ff[i+1] <= {quo_ff[i][VL_Q_W-2:0], bit_in[i]};
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   assign quo_out = quo_ff[VL_Q_W];

endmodule

FILE: rtl/muscl_slope_limiter.sv
// muscl slope limiter top level: slope dividers, limiter stages, output register, csr
// depends on msl_pkg, msl_slope_div, msl_vl_div
//
// channel   dir  handshake                 payload
// req       in   req_tvalid / req_tready   u_left, u_center, u_right, spacing_left/right
// rsp       out  rsp_tvalid / rsp_tready   slope, saturated
// csr       in   apb psel/penable/pready   limiter_mode at byte address 0
//
// one request accepted per cycle while the output register is free or being drained;
// depth set by the two bit-per-stage dividers (49 stages for slopes, 33 for van leer)
// reset clears valid bits and limiter_mode; payload registers are not reset
// the whole pipeline holds while a result waits and rsp_tready is low;
// bubbles are filled while the output register is free
module muscl_slope_limiter (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // u_left[31:0], u_center[63:32], u_right[95:64], spacing_left[126:96],
   // spacing_right[157:127], zero pad [159:158]
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // slope[31:0], saturated[32], zero pad [39:33]
   output logic [39:0]   rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import msl_pkg::*;

   localparam int SL_LAT = SNUM_W;
   localparam int VL_LAT = VL_Q_W;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              neg_l;
      logic              zero_l;
      logic              dz_l;
      logic              neg_r;
      logic              zero_r;
      logic              dz_r;
   } slope_sb_type;

   typedef struct packed {
      logic              is_vl;
      logic              same;
      logic              neg;
      logic              flag;
      logic [DATA_W-1:0] pre_val;
      logic              pre_clip;
   } vl_sb_type;

   // config register
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready & ~csr_paddr[2];
   assign mode_in = csr_wr ? csr_pwdata[MODE_W-1:0] : mode_ff;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-MODE_W){1'b0}}, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // global advance: output register free or being drained
   logic pipe_en;
   logic rsp_valid_ff;
   assign pipe_en = ~rsp_valid_ff | rsp_tready;
   assign req_tready = pipe_en;

   // input differences
   logic signed [DIFF_W-1:0] diff_l, diff_r;
   logic [DIFF_W-1:0]        mag_l, mag_r;
   logic [DX_W-1:0]          dx_l, dx_r;
   slope_sb_type             ssb_in;

   always_comb begin
      diff_l = DIFF_W'($signed(req_tdata[63:32])) - DIFF_W'($signed(req_tdata[31:0]));
      diff_r = DIFF_W'($signed(req_tdata[95:64])) - DIFF_W'($signed(req_tdata[63:32]));
      mag_l  = diff_l[DIFF_W-1] ? -diff_l : diff_l;
      mag_r  = diff_r[DIFF_W-1] ? -diff_r : diff_r;
      dx_l   = req_tdata[126:96];
      dx_r   = req_tdata[157:127];
      ssb_in.mode   = mode_ff;
      ssb_in.neg_l  = diff_l[DIFF_W-1];
      ssb_in.zero_l = (mag_l == '0);
      ssb_in.dz_l   = (dx_l == '0);
      ssb_in.neg_r  = diff_r[DIFF_W-1];
      ssb_in.zero_r = (mag_r == '0);
      ssb_in.dz_r   = (dx_r == '0);
   end

   // slope dividers, sideband and valid travel alongside
   logic [SNUM_W-1:0] quo_l, quo_r;

   msl_slope_div u_div_l (
      .clock   (clock),
      .en      (pipe_en),
      .mag_in  (mag_l),
      .dx_in   (dx_l),
      .quo_out (quo_l)
   );

   msl_slope_div u_div_r (
      .clock   (clock),
      .en      (pipe_en),
      .mag_in  (mag_r),
      .dx_in   (dx_r),
      .quo_out (quo_r)
   );

   slope_sb_type ssb_ff [0:SL_LAT];
   logic         sv_ff  [0:SL_LAT];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ssb_ff[0] <= ssb_in;
         for (int i = 0; i < SL_LAT; i++) begin
            ssb_ff[i+1] <= ssb_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SL_LAT; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         sv_ff[0] <= req_tvalid;
         for (int i = 0; i < SL_LAT; i++) begin
            sv_ff[i+1] <= sv_ff[i];
         end
      end
   end

   // stage a: saturate slopes, take magnitudes
   slope_sb_type      ssb_out;
   logic [SNUM_W-1:0] qe_l, qe_r;
   sat_type           sat_l, sat_r;
   logic signed [DATA_W-1:0] sl_in, sr_in;
   logic signed [DATA_W-1:0] sl_ff, sr_ff;
   logic [DATA_W-1:0] a_in, b_in, a_ff, b_ff;
   logic              same_in, same_ff, neg_ff, flag_a_ff;
   logic [MODE_W-1:0] mode_a_ff;
   logic              av_ff;

   always_comb begin
      ssb_out = ssb_ff[SL_LAT];
      // zero spacing gives the largest magnitude, zero difference gives zero
      qe_l = ssb_out.zero_l ? '0 : (ssb_out.dz_l ? '1 : quo_l);
      qe_r = ssb_out.zero_r ? '0 : (ssb_out.dz_r ? '1 : quo_r);
      sat_l = sat_mag(ssb_out.neg_l, qe_l);
      sat_r = sat_mag(ssb_out.neg_r, qe_r);
      sl_in = sat_l.val;
      sr_in = sat_r.val;
      a_in  = sl_in[DATA_W-1] ? -sl_in : sl_in;
      b_in  = sr_in[DATA_W-1] ? -sr_in : sr_in;
      same_in = ((sl_in > 0) && (sr_in > 0)) || ((sl_in < 0) && (sr_in < 0));
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sl_ff     <= sl_in;
         sr_ff     <= sr_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         same_ff   <= same_in;
         neg_ff    <= sl_in[DATA_W-1];
         flag_a_ff <= sat_l.clip | sat_r.clip;
         mode_a_ff <= ssb_out.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (pipe_en) begin
         av_ff <= sv_ff[SL_LAT];
      end
   end

   // stage b: linear, minmod, superbee and van leer operands
   logic signed [DATA_W:0] sum_w, lin_w;
   logic [DATA_W:0]        a2, b2, mn1, mn2, sbm;
   logic [DATA_W-1:0]      mmm;
   sat_type                mm_sat, sb_sat;
   logic [VL_N_W-1:0]      prod_w, vl_num;
   logic [VL_D_W-1:0]      vl_den;
   vl_sb_type              vsb_in;

   always_comb begin
      sum_w  = DATA_W'(0) + ($signed({sl_ff[DATA_W-1], sl_ff}) + $signed({sr_ff[DATA_W-1], sr_ff}));
      lin_w  = (sum_w + $signed({{DATA_W{1'b0}}, sum_w[DATA_W]})) >>> 1;
      a2     = {a_ff, 1'b0};
      b2     = {b_ff, 1'b0};
      mn1    = (a2 < {1'b0, b_ff}) ? a2 : {1'b0, b_ff};
      mn2    = ({1'b0, a_ff} < b2) ? {1'b0, a_ff} : b2;
      sbm    = (mn1 > mn2) ? mn1 : mn2;
      mmm    = (a_ff < b_ff) ? a_ff : b_ff;
      mm_sat = sat_mag(neg_ff, SNUM_W'(mmm));
      sb_sat = sat_mag(neg_ff, SNUM_W'(sbm));
      prod_w = a_ff * b_ff;
      vl_num = {prod_w[VL_N_W-2:0], 1'b0};
      vl_den = {1'b0, a_ff} + {1'b0, b_ff};

      vsb_in.is_vl    = (mode_a_ff == MODE_VAN_LEER);
      vsb_in.same     = same_ff;
      vsb_in.neg      = neg_ff;
      vsb_in.flag     = flag_a_ff;
      vsb_in.pre_val  = '0;
      vsb_in.pre_clip = 1'b0;
      case (mode_a_ff)
         MODE_LINEAR: begin
            vsb_in.pre_val = lin_w[DATA_W-1:0];
         end
         MODE_MINMOD: begin
            if (same_ff) begin
               vsb_in.pre_val  = mm_sat.val;
               vsb_in.pre_clip = mm_sat.clip;
            end
         end
         MODE_SUPERBEE: begin
            if (same_ff) begin
               vsb_in.pre_val  = sb_sat.val;
               vsb_in.pre_clip = sb_sat.clip;
            end
         end
         default: begin
            vsb_in.pre_val = '0;
         end
      endcase
   end

   // van leer divider; its input register doubles as stage b
   logic [VL_Q_W-1:0] vl_quo;

   msl_vl_div u_vl_div (
      .clock   (clock),
      .en      (pipe_en),
      .num_in  (vl_num),
      .den_in  (vl_den),
      .quo_out (vl_quo)
   );

   vl_sb_type vsb_ff [0:VL_LAT];
   logic      vv_ff  [0:VL_LAT];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         vsb_ff[0] <= vsb_in;
         for (int i = 0; i < VL_LAT; i++) begin
            vsb_ff[i+1] <= vsb_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= VL_LAT; i++) begin
            vv_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         vv_ff[0] <= av_ff;
         for (int i = 0; i < VL_LAT; i++) begin
            vv_ff[i+1] <= vv_ff[i];
         end
      end
   end

   // final select into the output register
   vl_sb_type         vsb_out;
   sat_type           vl_sat;
   logic [DATA_W-1:0] slope_in, slope_ff;
   logic              sat_in, sat_ff;

   always_comb begin
      vsb_out = vsb_ff[VL_LAT];
      vl_sat  = sat_mag(vsb_out.neg, SNUM_W'(vl_quo));
      if (vsb_out.is_vl) begin
         slope_in = vsb_out.same ? vl_sat.val : '0;
         sat_in   = vsb_out.flag | (vsb_out.same & vl_sat.clip);
      end else begin
         slope_in = vsb_out.pre_val;
         sat_in   = vsb_out.flag | vsb_out.pre_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         slope_ff <= slope_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= vv_ff[VL_LAT];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, sat_ff, slope_ff};

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for muscl_slope_limiter: directed extremes per mode, then random
// requests under three idling patterns; depends on msl_pkg and the rtl top level
module tb_top;
   import msl_pkg::*;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          DRAIN_CYCLES   = 120;
   localparam logic [2:0]  ADDR_MODE      = 3'd0;

   typedef struct packed {
      logic [31:0] slope;
      logic        saturated;
   } slope_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [159:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // model copy of the mode register
   logic [MODE_W-1:0] mode_shadow = MODE_OFF;
   slope_result_type  pending_slopes[$];
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                quiet_cycles = 0;

   always #5 clock = ~clock;

   muscl_slope_limiter DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clip a sign/magnitude pair to the 32-bit range, clip flag in bit 32
   function automatic logic [32:0] clip_signed(input bit neg, input logic [63:0] mag);
      logic [63:0] lim;
      logic [31:0] m;
      bit          clip;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      clip = mag > lim;
      m = clip ? lim[31:0] : mag[31:0];
      return {clip, neg ? (~m + 32'd1) : m};
   endfunction

   // one slope: difference over spacing in q16.16, truncated on the magnitude
   function automatic logic [32:0] cell_slope(input longint diff, input logic [30:0] dx);
      bit          neg;
      logic [63:0] mag;
      neg = diff < 0;
      mag = neg ? 64'(-diff) : 64'(diff);
      if (mag == 0) return 33'd0;
      if (dx == 0) return clip_signed(neg, 64'hffff_ffff_ffff_ffff);
      return clip_signed(neg, (mag << FRAC_BITS) / {33'd0, dx});
   endfunction

   function automatic slope_result_type limit_slopes(input logic [159:0] d);
      slope_result_type r;
      logic [32:0]   sl_c, sr_c, lim_c;
      longint        sl, sr, diff_l, diff_r;
      logic [63:0]   a, b, t1, t2;
      bit            same, neg;
      diff_l = longint'($signed(d[63:32])) - longint'($signed(d[31:0]));
      diff_r = longint'($signed(d[95:64])) - longint'($signed(d[63:32]));
      sl_c = cell_slope(diff_l, d[126:96]);
      sr_c = cell_slope(diff_r, d[157:127]);
      sl = longint'($signed(sl_c[31:0]));
      sr = longint'($signed(sr_c[31:0]));
      r.saturated = sl_c[32] | sr_c[32];
      r.slope = '0;
      same = (sl > 0 && sr > 0) || (sl < 0 && sr < 0);
      neg = sl < 0;
      a = neg ? 64'(-sl) : 64'(sl);
      b = (sr < 0) ? 64'(-sr) : 64'(sr);
      lim_c = '0;
      case (mode_shadow)
         MODE_LINEAR: begin
            sl = (sl + sr) / 2;
            r.slope = sl[31:0];
         end
         MODE_VAN_LEER: if (same) lim_c = clip_signed(neg, (2 * a * b) / (a + b));
         MODE_MINMOD:   if (same) lim_c = clip_signed(neg, (a < b) ? a : b);
         MODE_SUPERBEE: if (same) begin
            t1 = (2 * a < b) ? 2 * a : b;
            t2 = (a < 2 * b) ? a : 2 * b;
            lim_c = clip_signed(neg, (t1 > t2) ? t1 : t2);
         end
         default: ;
      endcase
      if (mode_shadow inside {MODE_VAN_LEER, MODE_MINMOD, MODE_SUPERBEE}) begin
         r.slope = lim_c[31:0];
         r.saturated = r.saturated | lim_c[32];
      end
      return r;
   endfunction

   // receiver stalls, changed at the falling edge
   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);

   // result checker against the oldest prediction
   always @(posedge clock) begin
      slope_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_slopes.size() == 0) begin
            $display("%0t unexpected result: actual slope %h saturated %b",
                     $time, rsp_tdata[31:0], rsp_tdata[32]);
            error_count++;
         end else begin
            want = pending_slopes.pop_front();
            if (rsp_tdata[31:0] !== want.slope) begin
               $display("%0t slope mismatch: expected %h actual %h",
                        $time, want.slope, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[32] !== want.saturated) begin
               $display("%0t saturated mismatch: expected %b actual %b",
                        $time, want.saturated, rsp_tdata[32]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // apb write: setup then access cycle
   task automatic write_mode(input logic [2:0] mode);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = ADDR_MODE;
      csr_pwdata = {29'd0, mode};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      mode_shadow = mode;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // stop offering requests, then wait for every result
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_slopes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // send one request, prediction made at the accepting edge
   task automatic send_cells(input logic [31:0] ul, input logic [31:0] uc,
                             input logic [31:0] ur, input logic [30:0] dxl,
                             input logic [30:0] dxr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {2'b00, dxr, dxl, ur, uc, ul};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_slopes.push_back(limit_slopes(req_tdata));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(8000000)) - 4000000);
         2: return 32'($signed($urandom_range(400)) - 200);
         3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [30:0] pick_spacing();
      logic [30:0] v;
      case ($urandom_range(4))
         0: v = 31'($urandom());
         1: v = 31'($urandom_range(1, 16));
         2: v = 31'h7fff_ffff;
         default: v = 31'($urandom_range(32768, 262144));
      endcase
      return (v == 0) ? 31'd1 : v;
   endfunction

   // extremes, sign changes, zero slopes and clipping in every mode
   task automatic test_directed();
      for (int m = MODE_OFF; m <= MODE_SUPERBEE; m++) begin
         drain_pipeline();
         write_mode(3'(m));
         send_cells(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'd1, 31'd1);
         send_cells(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 31'h1_0000, 31'h1_0000);
         send_cells(32'hffff_0000, 32'hfffe_0000, 32'hfffd_8000, 31'h0_8000,
                    31'h7fff_ffff);
         send_cells(32'h0005_0000, 32'h0005_0000, 32'h0009_0000, 31'h1_0000, 31'd3);
         send_cells(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff,
                    31'h2_0000);
      end
   endtask

   // mostly smooth profiles, some noise, mode changed every block of requests
   task automatic test_random(input int count);
      logic [31:0] uc;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            drain_pipeline();
            write_mode(3'($urandom_range(MODE_SUPERBEE)));
         end
         uc = pick_value();
         if ($urandom_range(3) == 0)
            send_cells(pick_value(), uc, pick_value(), pick_spacing(), pick_spacing());
         else
            send_cells(uc - 32'($signed($urandom_range(200000)) - 50000), uc,
                       uc + 32'($signed($urandom_range(200000)) - 50000),
                       pick_spacing(), pick_spacing());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 75;
      test_directed();
      test_random(420);
      send_idle_pct = 75;
      recv_idle_pct = 17;
      test_random(420);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(420);
      // end of stimulus
      @(negedge clock);
      req_tvalid = 1'b0;
      drain_pipeline();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
